[hdl/lru_page_buffer_pool_assert.svh]
// Assertion macros for the page buffer pool
`ifndef LRU_PAGE_BUFFER_POOL_ASSERT_SVH
`define LRU_PAGE_BUFFER_POOL_ASSERT_SVH
`ifndef SYNTHESIS
`define LPB_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LPB_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPB_ASSERT(label, clk, rstn, prop, msg)
`define LPB_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[hdl/lpb_pkg.sv]
package lpb_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned FileW = 8;
  localparam int unsigned PageW = 31;

  typedef enum logic [2:0] {
    CMD_READ = 3'd0, CMD_WRITE = 3'd1, CMD_FLUSH_PAGE = 3'd2,
    CMD_FLUSH_FILE = 3'd3, CMD_FLUSH_ALL = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_LOOKUP, ST_FLUSH, ST_EMIT
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic [FileW-1:0] file_id;
    logic [PageW-1:0] page_num;
    logic             touch;     // make selected slot most recent
    logic             free;      // free selected slot
    logic             fill;      // write key into selected slot
    logic             dirty_val; // dirty mark for fill
    logic             set_dirty; // hit on write
    logic [SlotW-1:0] sel;
  } cell_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic             hit;      // key match
    logic             file_hit; // file match
    logic [SlotW-1:0] rank;
    logic [FileW-1:0] file_id;
    logic [PageW-1:0] page_num;
  } cell_sts_t;
endpackage

[hdl/lpb_cell.sv]
module lpb_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [lpb_pkg::SlotW-1:0] idx_i,
  input  lpb_pkg::cell_ctl_t     ctl_i,
  input  logic                   sel_valid_i,
  input  logic [lpb_pkg::SlotW-1:0] sel_rank_i,
  output lpb_pkg::cell_sts_t     sts_o
);
  import lpb_pkg::*;

  logic             valid_q, valid_d, dirty_q, dirty_d;
  logic [SlotW-1:0] rank_q, rank_d;
  logic [FileW-1:0] file_q;
  logic [PageW-1:0] page_q;
  logic             me;

  assign me = (ctl_i.sel == idx_i);

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    rank_d  = rank_q;
    if (ctl_i.touch) begin
      if (me) begin
        rank_d = '0;
      end else if (valid_q && (!sel_valid_i || rank_q < sel_rank_i)) begin
        rank_d = rank_q + 1'b1;
      end
      if (me) begin
        valid_d = 1'b1;
        if (ctl_i.fill) dirty_d = ctl_i.dirty_val;
        if (ctl_i.set_dirty) dirty_d = 1'b1;
      end
    end
    if (ctl_i.free) begin
      if (me) begin
        valid_d = 1'b0;
        dirty_d = 1'b0;
        rank_d  = '0;
      end else if (valid_q && rank_q > sel_rank_i) begin
        rank_d = rank_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.touch && ctl_i.fill && me) begin
      file_q <= ctl_i.file_id;
      page_q <= ctl_i.page_num;
    end
  end

  always_comb begin
    sts_o.valid    = valid_q;
    sts_o.dirty    = dirty_q;
    sts_o.rank     = rank_q;
    sts_o.file_id  = file_q;
    sts_o.page_num = page_q;
    sts_o.file_hit = valid_q && (file_q == ctl_i.file_id);
    sts_o.hit      = sts_o.file_hit && (page_q == ctl_i.page_num);
  end
endmodule

[hdl/lru_page_buffer_pool.sv]
// Tag manager for a 16-slot fully associative page pool. Each slot is a cell
// holding its key, dirty mark and recency rank; the controller broadcasts
// the key and all cells compare in parallel. A read or write access first
// registers the item, then, once the result output can take it, compares
// and picks (hit, free queue head or the least recent slot) and updates ranks;
// the next item is accepted in the cycle after that. A flush frees matching
// slots in ascending order (free the slot, then let ranks settle and look
// ahead for the last flag), waiting while the previous result item is held;
// an input is taken only when idle.
`include "lru_page_buffer_pool_assert.svh"
module lru_page_buffer_pool (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // file_id[7:0], page_num[38:8]
  input  logic [2:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // slot[3:0], wb_file[11:4], wb_page[42:12]
  output logic [3:0]  m_axis_tuser,  // hit, fill_needed, writeback_needed, found
  output logic        m_axis_tlast   // last
);
  import lpb_pkg::*;

  state_e state_q, state_d;
  logic [2:0]       cmd_q;
  logic [FileW-1:0] fid_q;
  logic [PageW-1:0] pg_q;
  logic [SlotW-1:0] scan_q, scan_d;
  logic             any_q, any_d;
  logic [Slots-1:0][SlotW-1:0] fq_q;
  logic [SlotW-1:0] head_q, head_d;
  logic [SlotW:0]   cnt_q, cnt_d;
  logic             fq_push;
  logic [SlotW-1:0] fq_push_slot;

  cell_ctl_t ctl;
  cell_sts_t sts [Slots];
  logic [Slots-1:0] hit_v, match_v;

  logic        ov_q;
  logic [47:0] od_q, od_d;
  logic [3:0]  ou_q, ou_d;
  logic        ol_q, ol_d, o_load;
  logic        hit_any;
  logic [SlotW-1:0] hit_idx, lru_idx, nxt_idx;
  logic        nxt_any;

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    lpb_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i(SlotW'(g)),
      .ctl_i(ctl),
      .sel_valid_i(sts[ctl.sel].valid),
      .sel_rank_i(sts[ctl.sel].rank),
      .sts_o(sts[g])
    );
    assign hit_v[g] = sts[g].hit;
    assign match_v[g] = (SlotW'(g) >= scan_q) && sts[g].valid &&
      ((cmd_q == CMD_FLUSH_ALL) || (cmd_q == CMD_FLUSH_FILE && sts[g].file_hit) ||
       (cmd_q == CMD_FLUSH_PAGE && sts[g].hit));
  end

  always_comb begin
    hit_any = 1'b0; hit_idx = '0; lru_idx = '0; nxt_any = 1'b0; nxt_idx = '0;
    for (int i = 0; i < Slots; i++) begin
      if (hit_v[i]) begin hit_any = 1'b1; hit_idx = SlotW'(i); end
      if (sts[i].rank == SlotW'(Slots-1)) lru_idx = SlotW'(i);
    end
    for (int i = Slots-1; i >= 0; i--) begin
      if (match_v[i]) begin nxt_any = 1'b1; nxt_idx = SlotW'(i); end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

  always_comb begin
    state_d = state_q; scan_d = scan_q; any_d = any_q;
    head_d = head_q; cnt_d = cnt_q; fq_push = 1'b0; fq_push_slot = nxt_idx;
    ctl = '0; ctl.file_id = fid_q; ctl.page_num = pg_q;
    o_load = 1'b0; od_d = '0; ou_d = '0; ol_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser <= CMD_WRITE) state_d = ST_LOOKUP;
          else if (s_axis_tuser <= CMD_FLUSH_ALL) state_d = ST_FLUSH;
          scan_d = '0; any_d = 1'b0;
        end
      end
      ST_LOOKUP: begin
        if (!ov_q || m_axis_tready) begin
          o_load = 1'b1; ol_d = 1'b1; ctl.touch = 1'b1;
          state_d = ST_IDLE;
          if (hit_any) begin
            ctl.sel = hit_idx; ctl.set_dirty = (cmd_q == CMD_WRITE);
            od_d[3:0] = hit_idx; ou_d[0] = 1'b1;
          end else begin
            ctl.fill = 1'b1; ctl.dirty_val = (cmd_q == CMD_WRITE); ou_d[1] = 1'b1;
            if (cnt_q != '0) begin
              ctl.sel = fq_q[head_q]; head_d = head_q + 1'b1; cnt_d = cnt_q - 1'b1;
            end else begin
              ctl.sel = lru_idx;
              if (sts[lru_idx].dirty) begin
                ou_d[2] = 1'b1;
                od_d[11:4] = sts[lru_idx].file_id;
                od_d[42:12] = sts[lru_idx].page_num;
              end
            end
            od_d[3:0] = ctl.sel;
          end
        end
      end
      ST_FLUSH: begin
        if (!ov_q || m_axis_tready) begin
          if (nxt_any) begin
            o_load = 1'b1; ctl.free = 1'b1; ctl.sel = nxt_idx;
            od_d[3:0] = nxt_idx; ou_d[3] = 1'b1;
            if (sts[nxt_idx].dirty) begin
              ou_d[2] = 1'b1;
              od_d[11:4] = sts[nxt_idx].file_id;
              od_d[42:12] = sts[nxt_idx].page_num;
            end
            fq_push = 1'b1; cnt_d = cnt_q + 1'b1; any_d = 1'b1;
            if (nxt_idx == SlotW'(Slots-1)) begin
              ol_d = 1'b1; state_d = ST_IDLE;
            end else begin
              scan_d = nxt_idx + 1'b1; state_d = ST_EMIT;
            end
          end else begin
            // no more matches: terminate run
            state_d = ST_IDLE;
            if (any_q) begin
              // previous item keeps the last flag set by the lookahead; no new item is loaded
              ol_d = 1'b1;
            end else begin
              o_load = 1'b1; ol_d = 1'b1;
            end
          end
        end
      end
      ST_EMIT: begin
        // let ranks settle, with lookahead for the last flag
        if (nxt_any) state_d = ST_FLUSH;
        else state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; scan_q <= '0; any_q <= 1'b0;
      head_q <= '0; cnt_q <= (SlotW+1)'(Slots); ov_q <= 1'b0;
      for (int i = 0; i < Slots; i++) fq_q[i] <= SlotW'(i);
    end else begin
      state_q <= state_d; scan_q <= scan_d; any_q <= any_d;
      head_q <= head_d; cnt_q <= cnt_d;
      if (fq_push) fq_q[head_q + cnt_q[SlotW-1:0]] <= fq_push_slot;
      // hold a flush item that is not known to be last until the lookahead cycle
      if (o_load) ov_q <= ol_d;
      else if (state_q == ST_EMIT) ov_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser;
      fid_q <= s_axis_tdata[7:0];
      pg_q  <= s_axis_tdata[38:8];
    end
    if (o_load) begin
      od_q <= od_d; ou_q <= ou_d; ol_q <= ol_d;
    end
    if (state_q == ST_EMIT) ol_q <= !nxt_any;
  end

  `LPB_ASSERT(a_out_hold, clk_i, rst_ni, ov_q && !m_axis_tready |=> ov_q, "item dropped")
  `LPB_ASSERT(a_cnt, clk_i, rst_ni, cnt_q <= (SlotW+1)'(Slots), "free count overflow")
  `LPB_ASSERT(a_rdy, clk_i, rst_ni, s_axis_tready |-> state_q == ST_IDLE, "ready busy")
endmodule
